[rtl/atme_pkg.sv]
// Shared constants, types and tables of the 4x4 transform engine.
package atme_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int VAL_W        = 32;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int CRD_W        = 34;

   localparam logic [31:0] K_RAD  = 32'd2734261102;
   localparam logic [31:0] K_DEG  = 32'd3054198966;
   localparam logic [CRD_W-1:0] X_INIT = CRD_W'(652032874);

   localparam logic [3:0] OP_IDENT  = 4'd0;
   localparam logic [3:0] OP_TRANS  = 4'd1;
   localparam logic [3:0] OP_SCALE  = 4'd2;
   localparam logic [3:0] OP_ROTX   = 4'd3;
   localparam logic [3:0] OP_ROTY   = 4'd4;
   localparam logic [3:0] OP_ROTZ   = 4'd5;
   localparam logic [3:0] OP_WROPD  = 4'd6;
   localparam logic [3:0] OP_MULIN  = 4'd7;
   localparam logic [3:0] OP_MULOUT = 4'd8;
   localparam logic [3:0] OP_READ   = 4'd9;

   typedef struct packed {
      logic       accept;
      logic       cordic_start;
      logic       rot_apply;
      logic       mul_issue;
      logic [5:0] mul_cnt;
      logic       commit;
      logic       emit_tmp;
      logic [3:0] emit_idx;
      logic       emit_last;
   } atme_cmd_type;

   typedef struct packed {
      logic cordic_done;
      logic mul_done;
   } atme_stat_type;

   function automatic logic signed [VAL_W-1:0] ident_elem(input logic [3:0] idx);
      logic signed [VAL_W-1:0] one;
      one = VAL_W'(1) << FRAC_BITS;
      if (idx == 4'd0 || idx == 4'd5 || idx == 4'd10 || idx == 4'd15) begin
         return one;
      end
      return '0;
   endfunction

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      case (i)
         5'd0:  return 32'd536870912;
         5'd1:  return 32'd316933406;
         5'd2:  return 32'd167458907;
         5'd3:  return 32'd85004756;
         5'd4:  return 32'd42667331;
         5'd5:  return 32'd21354465;
         5'd6:  return 32'd10679838;
         5'd7:  return 32'd5340245;
         5'd8:  return 32'd2670163;
         5'd9:  return 32'd1335087;
         5'd10: return 32'd667544;
         5'd11: return 32'd333772;
         5'd12: return 32'd166886;
         5'd13: return 32'd83443;
         5'd14: return 32'd41722;
         5'd15: return 32'd20861;
         5'd16: return 32'd10430;
         5'd17: return 32'd5215;
         5'd18: return 32'd2608;
         5'd19: return 32'd1304;
         5'd20: return 32'd652;
         5'd21: return 32'd326;
         5'd22: return 32'd163;
         5'd23: return 32'd81;
         default: return 32'd0;
      endcase
   endfunction

endpackage

[rtl/atme_ifs.sv]
// Valid/ready channel interfaces for command items and result items.
interface atme_req_if;
   logic                 valid;
   logic                 ready;
   logic [3:0]           opcode;
   logic signed [31:0]   coord_x;
   logic signed [31:0]   coord_y;
   logic signed [31:0]   coord_z;
   logic signed [31:0]   rot_angle;
   logic                 angle_in_degrees;
   logic [3:0]           elem_index;
   logic signed [31:0]   elem_value;

   modport source (output valid, opcode, coord_x, coord_y, coord_z, rot_angle,
                   angle_in_degrees, elem_index, elem_value, input ready);
   modport sink   (input valid, opcode, coord_x, coord_y, coord_z, rot_angle,
                   angle_in_degrees, elem_index, elem_value, output ready);
endinterface

interface atme_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [3:0]           out_index;
   logic signed [31:0]   out_value;
   logic                 out_last;

   modport source (output valid, out_index, out_value, out_last, input ready);
   modport sink   (input valid, out_index, out_value, out_last, output ready);
endinterface

[rtl/atme_cordic.sv]
// Iterative CORDIC that turns a Q16.16 angle into sine and cosine.
module atme_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  angle,
   input  logic                deg,
   output logic                done,
   output logic signed [31:0]  sin_val,
   output logic signed [31:0]  cos_val
);
   import atme_pkg::*;

   localparam int RS = 30 - FRAC_BITS;
   localparam logic signed [CRD_W-1:0] HALF_C = CRD_W'(1) << (RS - 1);

   logic signed [64:0]       pmul_ff;
   logic                     deg_ff;
   logic                     load_ff, run_ff, fin_ff, done_ff;
   logic                     neg_ff;
   logic signed [CRD_W-1:0]  x_ff, y_ff, z_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [31:0]       sin_ff, cos_ff;

   logic [31:0]              ph, ph_t, ph_r;
   logic signed [CRD_W-1:0]  dx, dy, atn, c_r, s_r;

   always_comb begin
      ph   = deg_ff ? pmul_ff[FRAC_BITS+8 +: 32] : pmul_ff[FRAC_BITS+2 +: 32];
      ph_t = ph + 32'h4000_0000;
      ph_r = ph_t[31] ? (ph ^ 32'h8000_0000) : ph;
      dx   = y_ff >>> step_ff;
      dy   = x_ff >>> step_ff;
      atn  = CRD_W'(atan_entry(5'(step_ff)));
      c_r  = (x_ff + HALF_C) >>> RS;
      s_r  = (y_ff + HALF_C) >>> RS;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pmul_ff <= angle * $signed({1'b0, (deg ? K_DEG : K_RAD)});
         deg_ff  <= deg;
      end
      if (load_ff) begin
         neg_ff  <= ph_t[31];
         z_ff    <= CRD_W'($signed(ph_r));
         x_ff    <= X_INIT;
         y_ff    <= '0;
         step_ff <= '0;
      end else if (run_ff) begin
         if (!z_ff[CRD_W-1]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atn;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atn;
         end
         step_ff <= step_ff + 1'b1;
      end
      if (fin_ff) begin
         cos_ff <= neg_ff ? -c_r[31:0] : c_r[31:0];
         sin_ff <= neg_ff ? -s_r[31:0] : s_r[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         load_ff <= start;
         fin_ff  <= run_ff && (step_ff == STEP_W'(CORDIC_STEPS - 1));
         done_ff <= fin_ff;
         if (load_ff) begin
            run_ff <= 1'b1;
         end else if (run_ff && step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            run_ff <= 1'b0;
         end
      end
   end

   assign done    = done_ff;
   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

[rtl/atme_dpath.sv]
// Matrix storage, builders, shared multiply-accumulate unit and readout mux.
module atme_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  atme_pkg::atme_cmd_type   cmd,
   output atme_pkg::atme_stat_type  stat,
   input  logic [3:0]               opcode,
   input  logic signed [31:0]       coord_x,
   input  logic signed [31:0]       coord_y,
   input  logic signed [31:0]       coord_z,
   input  logic signed [31:0]       rot_angle,
   input  logic                     angle_in_degrees,
   input  logic [3:0]               elem_index,
   input  logic signed [31:0]       elem_value,
   output logic signed [31:0]       out_value
);
   import atme_pkg::*;

   localparam int ACC_W = 2 * VAL_W + 2;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(32'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SMIN = -(ACC_W'(1) <<< 31);

   logic signed [VAL_W-1:0]   cur_ff [16];
   logic signed [VAL_W-1:0]   opd_ff [16];
   logic signed [VAL_W-1:0]   tmp_ff [16];
   logic [3:0]                rop_ff;

   logic signed [2*VAL_W-1:0] prod_ff;
   logic                      v1_ff, fin_ff, done_ff;
   logic [1:0]                k1_ff;
   logic [3:0]                e1_ff, e2_ff;
   logic signed [ACC_W-1:0]   acc_ff;

   logic                      crd_done;
   logic signed [31:0]        sin_v, cos_v;
   logic [3:0]                a_idx, b_idx;
   logic signed [ACC_W-1:0]   rnd;
   logic signed [VAL_W-1:0]   sat_v;

   atme_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.cordic_start),
      .angle   (rot_angle),
      .deg     (angle_in_degrees),
      .done    (crd_done),
      .sin_val (sin_v),
      .cos_val (cos_v)
   );

   assign a_idx = {cmd.mul_cnt[5:4], cmd.mul_cnt[1:0]};
   assign b_idx = {cmd.mul_cnt[1:0], cmd.mul_cnt[3:2]};

   always_comb begin
      rnd = (acc_ff + HALF) >>> FRAC_BITS;
      if (rnd > SMAX) begin
         sat_v = 32'sh7FFF_FFFF;
      end else if (rnd < SMIN) begin
         sat_v = 32'sh8000_0000;
      end else begin
         sat_v = rnd[VAL_W-1:0];
      end
   end

   // Current matrix: builders, rotation load and product commit.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) cur_ff[i] <= ident_elem(4'(i));
      end else if (cmd.accept &&
                   (opcode == OP_IDENT || opcode == OP_TRANS || opcode == OP_SCALE)) begin
         for (int i = 0; i < 16; i++) cur_ff[i] <= ident_elem(4'(i));
         if (opcode == OP_TRANS) begin
            cur_ff[12] <= coord_x;
            cur_ff[13] <= coord_y;
            cur_ff[14] <= coord_z;
         end else if (opcode == OP_SCALE) begin
            cur_ff[0]  <= coord_x;
            cur_ff[5]  <= coord_y;
            cur_ff[10] <= coord_z;
         end
      end else if (cmd.rot_apply) begin
         for (int i = 0; i < 16; i++) cur_ff[i] <= ident_elem(4'(i));
         case (rop_ff)
            OP_ROTX: begin
               cur_ff[5] <= cos_v;  cur_ff[6]  <= sin_v;
               cur_ff[9] <= -sin_v; cur_ff[10] <= cos_v;
            end
            OP_ROTY: begin
               cur_ff[0] <= cos_v;  cur_ff[2]  <= -sin_v;
               cur_ff[8] <= sin_v;  cur_ff[10] <= cos_v;
            end
            default: begin
               cur_ff[0] <= cos_v;  cur_ff[1] <= sin_v;
               cur_ff[4] <= -sin_v; cur_ff[5] <= cos_v;
            end
         endcase
      end else if (cmd.commit) begin
         for (int i = 0; i < 16; i++) cur_ff[i] <= tmp_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) opd_ff[i] <= ident_elem(4'(i));
      end else if (cmd.accept && opcode == OP_WROPD) begin
         opd_ff[elem_index] <= elem_value;
      end
   end

   // Multiply-accumulate pipeline: product, accumulate, round and store.
   always_ff @(posedge clock) begin
      if (cmd.accept) rop_ff <= opcode;
      if (cmd.mul_issue) begin
         prod_ff <= cur_ff[a_idx] * opd_ff[b_idx];
         k1_ff   <= cmd.mul_cnt[1:0];
         e1_ff   <= cmd.mul_cnt[5:2];
      end
      if (v1_ff) begin
         acc_ff <= ((k1_ff == 2'd0) ? '0 : acc_ff) + ACC_W'(prod_ff);
         e2_ff  <= e1_ff;
      end
      if (fin_ff) tmp_ff[e2_ff] <= sat_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= cmd.mul_issue;
         fin_ff  <= v1_ff && (k1_ff == 2'd3);
         done_ff <= fin_ff && (e2_ff == 4'd15);
      end
   end

   assign stat.cordic_done = crd_done;
   assign stat.mul_done    = done_ff;
   assign out_value        = cmd.emit_tmp ? tmp_ff[cmd.emit_idx] : cur_ff[cmd.emit_idx];

endmodule

[rtl/atme_ctrl.sv]
// Command sequencer: accepts items, runs rotation and product phases, emits results.
module atme_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [3:0]               req_opcode,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output atme_pkg::atme_cmd_type   cmd,
   input  atme_pkg::atme_stat_type  stat
);
   import atme_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CORD  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_MWAIT = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [3:0] op_ff;
   logic [5:0] cnt_ff, cnt_in;
   logic [3:0] eidx_ff, eidx_in;
   logic       etmp_ff, etmp_in;
   logic       acc;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);
   assign acc       = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      eidx_in  = eidx_ff;
      etmp_in  = etmp_ff;
      cmd              = '0;
      cmd.accept       = acc;
      cmd.mul_cnt      = cnt_ff;
      cmd.emit_tmp     = etmp_ff;
      cmd.emit_idx     = eidx_ff;
      cmd.emit_last    = (eidx_ff == 4'd15);
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (req_opcode inside {OP_ROTX, OP_ROTY, OP_ROTZ}) begin
                  cmd.cordic_start = 1'b1;
                  state_in = S_CORD;
               end else if (req_opcode inside {OP_MULIN, OP_MULOUT}) begin
                  cnt_in   = '0;
                  state_in = S_MUL;
               end else if (req_opcode == OP_READ) begin
                  eidx_in  = '0;
                  etmp_in  = 1'b0;
                  state_in = S_EMIT;
               end
            end
         end
         S_CORD: begin
            if (stat.cordic_done) begin
               cmd.rot_apply = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_MUL: begin
            cmd.mul_issue = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd63) state_in = S_MWAIT;
         end
         S_MWAIT: begin
            if (stat.mul_done) begin
               if (op_ff == OP_MULIN) begin
                  cmd.commit = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  eidx_in  = '0;
                  etmp_in  = 1'b1;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               eidx_in = eidx_ff + 1'b1;
               if (eidx_ff == 4'd15) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         eidx_ff  <= '0;
         etmp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         eidx_ff  <= eidx_in;
         etmp_ff  <= etmp_in;
      end
      if (acc) op_ff <= req_opcode;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("result shown while taking items");
   a_mul_done_wait: assert property (@(posedge clock) disable iff (reset)
      stat.mul_done |-> state_ff == S_MWAIT) else $error("product done out of phase");
   a_cordic_wait: assert property (@(posedge clock) disable iff (reset)
      stat.cordic_done |-> state_ff == S_CORD) else $error("sine done out of phase");
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && eidx_ff == 4'd15) |=> state_ff == S_IDLE)
      else $error("readout did not end after last item");

endmodule

[rtl/affine_transform_matrix_engine_core.sv]
// Top level of the 4x4 fixed-point transform engine.
//
//   Channel   Direction  Handshake    Carries
//   req_chan  in         valid/ready  opcode, coordinates, angle, operand element
//   rsp_chan  out        valid/ready  out_index, out_value, out_last
//
// One item is worked on at a time; req_chan.ready is high only while idle.
// Builders and operand writes finish in the accept cycle. Rotations run
// through the single CORDIC iteration loop.
// Products issue 64 multiplies on one shared 32x32 multiplier into the accumulate pipeline,
// then 16 result items follow for a multiply-out; a read starts its 16 result items,
// one per cycle while rsp_chan.ready is high, in the cycle after it is accepted.
// Synchronous active-high reset loads identity into both matrices.
// A stalled result holds its index and value until rsp_chan.ready is seen.
module affine_transform_matrix_engine_core (
   input  logic         clock,
   input  logic         reset,
   atme_req_if.sink     req_chan,
   atme_rsp_if.source   rsp_chan
);
   import atme_pkg::*;

   atme_cmd_type  cmd;
   atme_stat_type stat;

   // The sequencer owns the handshakes and tells the datapath what to do.
   atme_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // The datapath holds both matrices, the CORDIC and the multiply-accumulate unit.
   atme_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .opcode           (req_chan.opcode),
      .coord_x          (req_chan.coord_x),
      .coord_y          (req_chan.coord_y),
      .coord_z          (req_chan.coord_z),
      .rot_angle        (req_chan.rot_angle),
      .angle_in_degrees (req_chan.angle_in_degrees),
      .elem_index       (req_chan.elem_index),
      .elem_value       (req_chan.elem_value),
      .out_value        (rsp_chan.out_value)
   );

   // Index and last flag of a result item come straight from the readout counter.
   assign rsp_chan.out_index = cmd.emit_idx;
   assign rsp_chan.out_last  = cmd.emit_last;

endmodule
